/* sv/ffge_pkg.sv */
// Package for the frame-store fill and glyph engine.
// Screen geometry, derived widths, command codes and shared types.
// No dependencies.
package ffge_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int DEPTH         = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int Y_W           = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    localparam int GLYPH_MAX = 16;
    localparam int COL_MAX   = (SCREEN_WIDTH > GLYPH_MAX) ? SCREEN_WIDTH : GLYPH_MAX;
    localparam int COL_W     = $clog2(COL_MAX + 1);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT + 1);

    localparam int CMD_W   = 2;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int GW_W    = 5;
    localparam int BYTE_W  = 8;

    localparam logic [GW_W-1:0] GW_RESET = 5'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLOT  = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_GLYPH = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COLOR_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic valid;
        logic off_screen;
    } t_res_req;

    function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
        return {c[BYTE_W-1:0], c[COLOR_W-1:BYTE_W]};
    endfunction

endpackage

/* sv/ffge_if.sv */
// Stream interfaces for the command and response channels.
// Depends on ffge_pkg for field widths.
interface ffge_cmd_if import ffge_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [COLOR_W-1:0] glyph_row_bits;

    modport source (output valid, command, x_pos, y_pos, rect_width, rect_height,
                    fg_color, bg_color, glyph_row_bits, input ready);
    modport sink   (input valid, command, x_pos, y_pos, rect_width, rect_height,
                    fg_color, bg_color, glyph_row_bits, output ready);
endinterface

interface ffge_rsp_if import ffge_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_word;
    logic               off_screen;

    modport source (output valid, pixel_word, off_screen, input ready);
    modport sink   (input valid, pixel_word, off_screen, output ready);
endinterface

/* sv/ffge_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ffge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/ffge_draw.sv */
// Command sequencer: clearing pass, coordinate clipping and the pixel walker
// that drives the frame store ports. Depends on ffge_pkg and ffge_if.
module ffge_draw import ffge_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ffge_cmd_if.sink        i_cmd,
    input  logic            i_cfg_we,
    input  logic [GW_W-1:0] i_cfg_wdata,
    output t_wr_req         o_wr,
    output t_rd_req         o_rd,
    output t_res_req        o_res,
    input  logic            i_res_ack
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_BASE, S_START, S_WALK, S_RDREQ, S_RDWAIT
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [GW_W-1:0]     r_gw;
    t_cmd                r_cmd;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [COORD_W-1:0]  r_w;
    logic [COORD_W-1:0]  r_h;
    logic [COLOR_W-1:0]  r_fg;
    logic [COLOR_W-1:0]  r_bg;
    logic [COLOR_W-1:0]  r_bits;
    logic [ADDR_W-1:0]   r_row_base;
    logic [COL_W-1:0]    r_cols;
    logic [ROW_W-1:0]    r_rows;
    logic [COL_W-1:0]    r_cnt_col;
    logic [ROW_W-1:0]    r_cnt_row;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_skip;
    logic [COORD_W:0]    r_col;
    logic                r_off;

    logic               x_on, y_on;
    logic [COORD_W-1:0] w_room, h_room, w_eff, h_eff;
    logic [GW_W-1:0]    glyph_n;
    logic               col_on;

    assign x_on    = r_x < COORD_W'(SCREEN_WIDTH);
    assign y_on    = r_y < COORD_W'(SCREEN_HEIGHT);
    assign w_room  = COORD_W'(SCREEN_WIDTH) - r_x;
    assign h_room  = COORD_W'(SCREEN_HEIGHT) - r_y;
    assign w_eff   = (r_w > w_room) ? w_room : r_w;
    assign h_eff   = (r_h > h_room) ? h_room : r_h;
    assign glyph_n = (r_gw > GW_W'(GLYPH_MAX)) ? GW_W'(GLYPH_MAX) : r_gw;
    assign col_on  = r_col < (COORD_W + 1)'(SCREEN_WIDTH);

    assign i_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.addr = r_addr;
        o_wr.data = r_fg;
        case (r_state)
            S_CLEAR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_clr_addr;
                o_wr.data = '0;
            end
            S_WALK: begin
                o_wr.en = col_on;
                // glyph rows pick background on clear bits, fill and plot always fg
                if (r_cmd == CMD_GLYPH && !r_bits[COLOR_W-1]) begin
                    o_wr.data = r_bg;
                end
            end
            default: ;
        endcase
    end

    assign o_rd.en          = (r_state == S_RDREQ);
    assign o_rd.addr        = r_addr;
    assign o_res.valid      = (r_state == S_RDWAIT);
    assign o_res.off_screen = r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_gw       <= GW_RESET;
        end else begin
            if (i_cfg_we) begin
                r_gw <= i_cfg_wdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= t_cmd'(i_cmd.command);
                        r_x     <= i_cmd.x_pos;
                        r_y     <= i_cmd.y_pos;
                        r_w     <= i_cmd.rect_width;
                        r_h     <= i_cmd.rect_height;
                        r_fg    <= swap_bytes(i_cmd.fg_color);
                        r_bg    <= swap_bytes(i_cmd.bg_color);
                        r_bits  <= i_cmd.glyph_row_bits;
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_row_base <= ADDR_W'(r_y[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH);
                    r_off      <= !(x_on && y_on);
                    case (r_cmd)
                        CMD_PLOT: begin
                            r_cols <= COL_W'(1);
                            r_rows <= (x_on && y_on) ? ROW_W'(1) : '0;
                        end
                        CMD_FILL: begin
                            r_cols <= COL_W'(w_eff);
                            r_rows <= (x_on && y_on) ? ROW_W'(h_eff) : '0;
                        end
                        CMD_GLYPH: begin
                            r_cols <= COL_W'(glyph_n);
                            r_rows <= y_on ? ROW_W'(1) : '0;
                        end
                        default: begin
                            r_cols <= '0;
                            r_rows <= '0;
                        end
                    endcase
                    r_state <= S_START;
                end
                S_START: begin
                    r_addr    <= r_row_base + ADDR_W'(r_x);
                    r_col     <= {1'b0, r_x};
                    r_cnt_col <= r_cols;
                    r_cnt_row <= r_rows;
                    // last pixel of a row to first pixel of the next
                    r_skip    <= ADDR_W'(SCREEN_WIDTH) - ADDR_W'(r_cols) + 1'b1;
                    if (r_cmd == CMD_READ) begin
                        r_state <= r_off ? S_RDWAIT : S_RDREQ;
                    end else if (r_cols == '0 || r_rows == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_bits <= r_bits << 1;
                    if (r_cnt_col == COL_W'(1)) begin
                        if (r_cnt_row == ROW_W'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt_row <= r_cnt_row - 1'b1;
                            r_cnt_col <= r_cols;
                            r_addr    <= r_addr + r_skip;
                            r_col     <= {1'b0, r_x};
                        end
                    end else begin
                        r_cnt_col <= r_cnt_col - 1'b1;
                        r_addr    <= r_addr + 1'b1;
                        r_col     <= r_col + 1'b1;
                    end
                end
                S_RDREQ: begin
                    r_state <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/framebuffer_fill_and_glyph_engine.sv */
// Frame-store fill and glyph engine, top level: frame store, sequencer and
// response register. Depends on ffge_pkg, ffge_if, ffge_ram and ffge_draw.
//
// Usage:
//   i_cmd is a valid/ready command stream (plot, fill, glyph row, read).
//   o_rsp carries one transaction per read command: the stored byte-swapped
//   word and an off-screen flag; other commands give no response.
//   i_cfg_we/i_cfg_wdata write the glyph width; write it only while idle.
//   Commands run one at a time. After accepting one the sequencer clips
//   coordinates in S_BASE and sets up the address in S_START, then writes one
//   pixel per cycle through the single frame store write port: a plot writes
//   one pixel, a fill the clipped width * clipped height, a glyph row up to
//   the glyph width clamped to 16, and a clipped-away command nothing.
//   An on-screen read reads the store in S_RDREQ, then offers the word in
//   S_RDWAIT; an off-screen read skips the store and goes straight to S_RDWAIT.
//   The response sits in an output register, so the next command is taken
//   while it waits; a second read stalls until that register is free.
//   Reset starts a clearing pass that zeroes all 76800 words, one per cycle;
//   i_cmd.ready stays low until the pass ends. Config writes work throughout.
module framebuffer_fill_and_glyph_engine import ffge_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ffge_cmd_if.sink        i_cmd,
    ffge_rsp_if.source      o_rsp,
    input  logic            i_cfg_we,
    input  logic [GW_W-1:0] i_cfg_wdata
);

    t_wr_req            wr;
    t_rd_req            rd;
    t_res_req           res;
    logic               res_ack;
    logic [COLOR_W-1:0] rd_data;

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_word;
    logic               r_out_off;

    ffge_draw u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr        (wr),
        .o_rd        (rd),
        .o_res       (res),
        .i_res_ack   (res_ack)
    );

    ffge_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.addr),
        .o_rd_data (rd_data)
    );

    assign res_ack = res.valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out_word <= res.off_screen ? '0 : rd_data;
            r_out_off  <= res.off_screen;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.pixel_word = r_out_word;
    assign o_rsp.off_screen = r_out_off;

endmodule

/* sv/ffge_checker.sv */
// Port-level checks for the frame-store engine, bound to the top level.
// Depends on ffge_pkg for field widths.
module ffge_checker import ffge_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cmd_valid,
    input logic               i_cmd_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [COLOR_W-1:0] i_rsp_word,
    input logic               i_rsp_off
);

    // clearing pass holds off commands right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ready)
        else $error("command ready right after reset");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("command accepted back to back");

    a_off_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_off) |-> (i_rsp_word == '0))
        else $error("off-screen read with nonzero word");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_word) && $stable(i_rsp_off)))
        else $error("stalled response changed");

endmodule

bind framebuffer_fill_and_glyph_engine ffge_checker u_ffge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_word  (o_rsp.pixel_word),
    .i_rsp_off   (o_rsp.off_screen)
);
